[design/gregorian_date_add_days_top_defines.svh]
// assertion macros for the checker file
`ifndef GREGORIAN_DATE_ADD_DAYS_TOP_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_TOP_DEFINES_SVH

// property checked outside reset
`define GDAD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define GDAD_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/gdad_pkg.sv]
// shared types, constants and month length function for the date adder
`default_nettype none

package gdad_pkg;

   localparam int YEAR_W     = 14;
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int ADD_W      = 15;
   // running year may pass the input range while walking
   localparam int YACC_W     = 15;
   // day count: day + add + up to a year of month lengths
   localparam int REM_W      = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   localparam logic [YEAR_W-1:0]  CYCLE_YEARS = 14'd400;
   localparam logic [YEAR_W-1:0]  CYCLE_LAST  = 14'd399;
   localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_SUM,
      ST_WALK,
      ST_FIN
   } gdad_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic reduce;
      logic check;
      logic sum;
      logic walk_init;
      logic walk;
      logic out_load;
   } gdad_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic cycle_ge;
      logic date_bad;
      logic sum_done;
      logic walk_more;
   } gdad_sts_type;

   // days in a month, zero for a month number that means nothing
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      len = '0;
      if (month inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
         len = 5'd31;
      end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
         len = 5'd30;
      end else if (month == MONTH_FEB) begin
         len = leap ? 5'd29 : 5'd28;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

[design/gregorian_date_add_days_top.sv]
// Gregorian date plus day count, one request at a time.
// A request goes through 400 year reduction and a date check; a good date then gets
// the day of year sum and the month walk, one month per cycle at about 30.4 days each.
// A request is taken only while idle.
// A new request is taken while the previous result waits in the output register.
// Reset (synchronous, active high) clears the controller and result valid only.
`default_nettype none

module gregorian_date_add_days_top (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // start_year[13:0], start_month[17:14], start_day[22:18], days_to_add[37:23]
   input  wire [gdad_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // new_year[13:0], new_month[17:14], new_day[22:18]
   output logic [gdad_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // bad_input[0]
   output logic                                 rsp_tuser
);
   import gdad_pkg::*;

   gdad_cmd_type cmd;
   gdad_sts_type sts;

   // sequencing
   gdad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // arithmetic and result register
   gdad_dp u_dp (
      .clock     (clock),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

[design/gdad_ctrl.sv]
// controller state machine sequencing the date adder datapath
`default_nettype none

module gdad_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   input  gdad_pkg::gdad_sts_type sts,
   output gdad_pkg::gdad_cmd_type cmd
);
   import gdad_pkg::*;

   gdad_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // result register can take a new result
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (!sts.cycle_ge) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = sts.date_bad ? ST_FIN : ST_SUM;
         end
         ST_SUM: begin
            if (sts.sum_done) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (!sts.walk_more) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands and handshake outputs
   always_comb begin
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            // no request taken while reset is held
            req_tready = !reset;
            cmd.load   = req_tvalid && !reset;
         end
         ST_REDUCE: begin
            cmd.reduce = sts.cycle_ge;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
         end
         ST_SUM: begin
            cmd.sum       = !sts.sum_done;
            cmd.walk_init = sts.sum_done;
         end
         ST_WALK: begin
            cmd.walk = sts.walk_more;
         end
         ST_FIN: begin
            cmd.out_load = out_free;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[design/gdad_dp.sv]
// datapath: year cycle reduction, day of year sum and month walk
`default_nettype none

module gdad_dp (
   input  wire                                  clock,
   input  wire [gdad_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  gdad_pkg::gdad_cmd_type               cmd,
   output gdad_pkg::gdad_sts_type               sts,
   output logic [gdad_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tuser
);
   import gdad_pkg::*;

   logic [YACC_W-1:0]  year_ff, year_in;
   logic [YEAR_W-1:0]  ycyc_ff, ycyc_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff, day_in;
   logic [MONTH_W-1:0] m_ff, m_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic               bad_ff, bad_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic               out_bad_ff, out_bad_in;

   logic [YEAR_W-1:0]  req_year;
   logic [MONTH_W-1:0] req_month;
   logic [DAY_W-1:0]   req_day;
   logic [ADD_W-1:0]   req_add;
   logic               leap;
   logic [DAY_W-1:0]   len;
   logic               date_bad;

   // request fields
   assign req_year  = req_tdata[13:0];
   assign req_month = req_tdata[17:14];
   assign req_day   = req_tdata[22:18];
   assign req_add   = req_tdata[37:23];

   // leap rule on the year within its 400 year cycle
   assign leap = (ycyc_ff[1:0] == 2'b00) &&
                 !(ycyc_ff inside {14'd100, 14'd200, 14'd300});
   assign len  = month_len(m_ff, leap);

   // starting date check
   assign date_bad = (month_ff == '0) || (month_ff > MONTH_DEC) || (day_ff == '0) ||
                     (day_ff > month_len(month_ff, leap));

   // status to the controller
   always_comb begin
      sts.cycle_ge  = ycyc_ff >= CYCLE_YEARS;
      sts.date_bad  = date_bad;
      sts.sum_done  = m_ff == month_ff;
      sts.walk_more = rem_ff > {{(REM_W-DAY_W){1'b0}}, len};
   end

   // next values of the working registers
   always_comb begin
      year_in     = year_ff;
      ycyc_in     = ycyc_ff;
      month_in    = month_ff;
      day_in      = day_ff;
      m_in        = m_ff;
      rem_in      = rem_ff;
      bad_in      = bad_ff;
      out_data_in = out_data_ff;
      out_bad_in  = out_bad_ff;
      if (cmd.load) begin
         year_in  = {1'b0, req_year};
         ycyc_in  = req_year;
         month_in = req_month;
         day_in   = req_day;
         m_in     = MONTH_JAN;
         rem_in   = {{(REM_W-DAY_W){1'b0}}, req_day} + {{(REM_W-ADD_W){1'b0}}, req_add};
      end
      if (cmd.reduce) begin
         ycyc_in = ycyc_ff - CYCLE_YEARS;
      end
      if (cmd.check) begin
         bad_in = date_bad;
      end
      if (cmd.sum) begin
         rem_in = rem_ff + {{(REM_W-DAY_W){1'b0}}, len};
         m_in   = m_ff + 4'd1;
      end
      if (cmd.walk_init) begin
         m_in = MONTH_JAN;
      end
      // take one month off, rolling into the next year after december
      if (cmd.walk) begin
         rem_in = rem_ff - {{(REM_W-DAY_W){1'b0}}, len};
         if (m_ff == MONTH_DEC) begin
            m_in    = MONTH_JAN;
            year_in = year_ff + 15'd1;
            ycyc_in = (ycyc_ff == CYCLE_LAST) ? '0 : ycyc_ff + 14'd1;
         end else begin
            m_in = m_ff + 4'd1;
         end
      end
      // bad dates pass through unchanged
      if (cmd.out_load) begin
         out_bad_in = bad_ff;
         if (bad_ff) begin
            out_data_in = {1'b0, day_ff, month_ff, year_ff[YEAR_W-1:0]};
         end else begin
            out_data_in = {1'b0, rem_ff[DAY_W-1:0], m_ff, year_ff[YEAR_W-1:0]};
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      year_ff     <= year_in;
      ycyc_ff     <= ycyc_in;
      month_ff    <= month_in;
      day_ff      <= day_in;
      m_ff        <= m_in;
      rem_ff      <= rem_in;
      bad_ff      <= bad_in;
      out_data_ff <= out_data_in;
      out_bad_ff  <= out_bad_in;
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_bad_ff;

endmodule

`default_nettype wire

[design/gdad_checker.sv]
// port level checks for the date adder, bound to the top level
`default_nettype none
`include "gregorian_date_add_days_top_defines.svh"

module gdad_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [39:0] req_tdata,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [23:0] rsp_tdata,
   input wire        rsp_tuser
);

   // no result straight out of reset
   `GDAD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "result valid after reset")

   // a result holds until taken
   `GDAD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // one request at a time
   `GDAD_ASSERT(a_one_busy, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while busy")

   // a good result has a month from 1 to 12 and a nonzero day
   `GDAD_ASSERT(a_good_date, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata[17:14] != 4'd0 && rsp_tdata[17:14] <= 4'd12 && rsp_tdata[22:18] != 5'd0, "result date out of range")

endmodule

bind gregorian_date_add_days_top gdad_checker u_gdad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the gregorian date adder
`timescale 1ns / 1ps

module tb_top;
   import gdad_pkg::*;

   // one request: a starting date and a day count
   typedef struct {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [ADD_W-1:0]   add;
      bit                 drain_first;   // hold off until every result is back
   } date_req_type;

   // one result date with its bad input flag
   typedef struct {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic               bad;
   } date_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   wire                   rsp_tuser;

   date_req_type pending_reqs[$];
   date_rsp_type expected_dates[$];
   int unsigned fail_count = 0;
   bit req_seen = 1'b0;

   gregorian_date_add_days_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock, 4 ns period
   initial begin
      forever #2 clock = ~clock;
   end

   // reset held from the start, released on a falling edge
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // gregorian leap rule, year 0 included
   function automatic bit is_leap(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
   endfunction

   // month length, zero for a month number outside the calendar
   function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return is_leap(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // expected date after adding the count, walking month by month
   function automatic date_rsp_type add_days_expected(input date_req_type r);
      date_rsp_type res;
      int unsigned yr;
      int unsigned mo;
      int unsigned rem;
      yr = 32'(r.year);
      res.year  = r.year;
      res.month = r.month;
      res.day   = r.day;
      res.bad   = 1'b1;
      if (r.month < MONTH_JAN || r.month > MONTH_DEC || r.day == 0 ||
          32'(r.day) > days_in_month(yr, 32'(r.month))) begin
         return res;
      end
      // day of year first, then add the count on top
      rem = 32'(r.day) + 32'(r.add);
      for (mo = 32'(MONTH_JAN); mo < 32'(r.month); mo++) begin
         rem += days_in_month(yr, mo);
      end
      mo = 32'(MONTH_JAN);
      while (rem > days_in_month(yr, mo)) begin
         rem -= days_in_month(yr, mo);
         mo++;
         if (mo > 32'(MONTH_DEC)) begin
            mo = 32'(MONTH_JAN);
            yr++;
         end
      end
      res.year  = YEAR_W'(yr);       // wraps at the field width
      res.month = MONTH_W'(mo);
      res.day   = DAY_W'(rem);
      res.bad   = 1'b0;
      return res;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_req(input date_req_type r);
      logic [REQ_DATA_W-1:0] v;
      v = '0;
      v[YEAR_W-1:0] = r.year;
      v[YEAR_W +: MONTH_W] = r.month;
      v[YEAR_W+MONTH_W +: DAY_W] = r.day;
      v[YEAR_W+MONTH_W+DAY_W +: ADD_W] = r.add;
      return v;
   endfunction

   function automatic date_req_type unpack_req(input logic [REQ_DATA_W-1:0] v);
      date_req_type r;
      r.year  = v[YEAR_W-1:0];
      r.month = v[YEAR_W +: MONTH_W];
      r.day   = v[YEAR_W+MONTH_W +: DAY_W];
      r.add   = v[YEAR_W+MONTH_W+DAY_W +: ADD_W];
      r.drain_first = 1'b0;
      return r;
   endfunction

   function automatic date_req_type make_req(input int unsigned y, input int unsigned m,
                                             input int unsigned d, input int unsigned a);
      date_req_type r;
      r.year  = YEAR_W'(y);
      r.month = MONTH_W'(m);
      r.day   = DAY_W'(d);
      r.add   = ADD_W'(a);
      r.drain_first = 1'b0;
      return r;
   endfunction

   // random request, mostly well formed with small counts
   function automatic date_req_type random_req();
      int unsigned y;
      int unsigned m;
      int unsigned d;
      int unsigned a;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: y = $urandom_range(1, 9999);
         5, 6:          y = $urandom_range(0, 163) * 100 + $urandom_range(0, 4);
         7:             y = $urandom_range(0, 40) * 400;
         default:       y = $urandom_range(0, 16383);
      endcase
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14: a = $urandom_range(0, 400);
         15, 16:  a = $urandom_range(0, 3000);
         17, 18:  a = $urandom_range(0, 32767);
         default: a = ($urandom_range(0, 1) == 0) ? 32767 - $urandom_range(0, 15) : 0;
      endcase
      if ($urandom_range(0, 4) == 0) begin
         // noise: any field value, valid or not
         m = $urandom_range(0, 15);
         d = $urandom_range(0, 31);
      end else begin
         m = $urandom_range(1, 12);
         case ($urandom_range(0, 5))
            0:       d = days_in_month(y, m);
            1:       d = 1;
            default: d = $urandom_range(1, days_in_month(y, m));
         endcase
      end
      return make_req(y, m, d, a);
   endfunction

   // stimulus: directed corners, then random requests
   initial begin : stim_blk
      date_req_type r;
      int i;
      pending_reqs.push_back(make_req(1, 1, 1, 0));
      pending_reqs.push_back(make_req(9999, 12, 31, 32767));
      pending_reqs.push_back(make_req(2000, 2, 29, 1));
      pending_reqs.push_back(make_req(1900, 2, 29, 0));        // not a leap year
      pending_reqs.push_back(make_req(2024, 2, 29, 365));
      pending_reqs.push_back(make_req(2023, 2, 29, 5));        // bad day in february
      pending_reqs.push_back(make_req(2023, 0, 10, 5));        // month zero
      pending_reqs.push_back(make_req(2023, 13, 10, 5));
      pending_reqs.push_back(make_req(16383, 15, 31, 32767));  // bad month, all ones
      pending_reqs.push_back(make_req(2023, 5, 0, 5));         // day zero
      pending_reqs.push_back(make_req(2023, 4, 31, 5));        // past end of april
      pending_reqs.push_back(make_req(2024, 12, 31, 1));       // year rollover
      pending_reqs.push_back(make_req(0, 2, 29, 10));          // year zero is leap
      pending_reqs.push_back(make_req(0, 1, 1, 0));
      pending_reqs.push_back(make_req(16383, 12, 31, 32767));  // year wraps
      pending_reqs.push_back(make_req(2100, 2, 28, 1));
      pending_reqs.push_back(make_req(1, 1, 31, 32767));
      pending_reqs.push_back(make_req(2400, 2, 29, 0));
      pending_reqs.push_back(make_req(10000, 3, 1, 100));      // year past the usual range
      pending_reqs.push_back(make_req(1999, 12, 31, 0));
      pending_reqs.push_back(make_req(16000, 2, 29, 16384));
      for (i = 0; i < 480; i++) begin
         r = random_req();
         if ((i % 97) == 50) begin
            r.drain_first = 1'b1;
         end
         pending_reqs.push_back(r);
      end

      // all requests accepted, then every result back
      @(negedge reset);
      while (pending_reqs.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
      while (expected_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (1200) @(posedge clock);
      if (fail_count == 0) begin
         $display("** gregorian_date_add_days_top: PASSED **");
      end else begin
         $display("** gregorian_date_add_days_top: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #25_000_000;
      $display("** gregorian_date_add_days_top: FAILED **");
      $finish;
   end

   // request driver: bursts with random gaps, falling edge
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   always @(negedge clock) begin : drv_blk
      date_req_type nxt;
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_seen) begin
         next_valid = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end else if (pending_reqs.size() != 0 &&
                      (!pending_reqs[0].drain_first || expected_dates.size() == 0)) begin
            nxt = pending_reqs.pop_front();
            req_tdata <= pack_req(nxt);
            next_valid = 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               case ($urandom_range(0, 7))
                  0, 1:    gap_left = 0;
                  7:       gap_left = $urandom_range(30, 400);
                  default: gap_left = $urandom_range(1, 25);
               endcase
            end else begin
               burst_left--;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // result receiver: stalls in phases of its own
   int unsigned rsp_phase_left = 0;
   int unsigned rsp_mode = 1;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_phase_left == 0) begin
            rsp_mode = $urandom_range(0, 3);
            rsp_phase_left = $urandom_range(1, 60);
         end else begin
            rsp_phase_left--;
         end
         case (rsp_mode)
            0:       rsp_tready <= 1'b0;
            1:       rsp_tready <= ($urandom_range(0, 1) == 1);
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   // monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin : mon_blk
      date_rsp_type want;
      date_rsp_type got;
      req_seen = !reset && req_tvalid && req_tready;
      if (req_seen) begin
         expected_dates.push_back(add_days_expected(unpack_req(req_tdata)));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.year  = rsp_tdata[YEAR_W-1:0];
         got.month = rsp_tdata[YEAR_W +: MONTH_W];
         got.day   = rsp_tdata[YEAR_W+MONTH_W +: DAY_W];
         got.bad   = rsp_tuser;
         if (expected_dates.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: result with nothing expected: %0d-%0d-%0d bad=%0b",
                        $realtime, got.year, got.month, got.day, got.bad);
            end
         end else begin
            want = expected_dates.pop_front();
            if (got.year !== want.year || got.month !== want.month ||
                got.day !== want.day || got.bad !== want.bad) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: mismatch: expected %0d-%0d-%0d bad=%0b, got %0d-%0d-%0d bad=%0b",
                           $realtime, want.year, want.month, want.day, want.bad,
                           got.year, got.month, got.day, got.bad);
               end
            end
         end
      end
   end

endmodule
